// ===== hdl/lbs_pkg.sv =====
// shared constants, widths and control types of the skinning unit
`default_nettype none

package lbs_pkg;

  // store geometry
  localparam int MAX_BONES        = 64;
  localparam int ENTRIES_PER_BONE = 12;
  localparam int STORE_DEPTH      = MAX_BONES * ENTRIES_PER_BONE;
  localparam int STORE_AW         = $clog2(STORE_DEPTH);

  // number formats
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;

  // field widths
  localparam int BONE_W   = 6;
  localparam int ENTRY_W  = 4;
  localparam int DATA_W   = 32;
  localparam int WEIGHT_W = 17;
  localparam int AXES     = 3;

  // datapath widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int T_W    = RSUM_W - FRAC_BITS;
  localparam int WP_W   = T_W + WEIGHT_BITS + 2;
  localparam int ACC_W  = 64;

  // stream widths
  localparam int IN_TDATA_W  = 160;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = AXES * DATA_W;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TERM = 1'b1;

  // sequencing
  localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ENTRIES_PER_BONE - 1);
  localparam int                 DRAIN_CYCLES = 4;
  localparam logic [1:0]         TRANS_COL = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_BITS);

  typedef struct packed {
    logic               accept;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_entry;
    logic               out_load;
  } lbs_cmd_t;

  typedef struct packed {
    logic out_valid;
  } lbs_status_t;

endpackage

`default_nettype wire

// ===== hdl/linear_blend_skinning_unit.sv =====
// top level of the linear blend skinning unit: stream ports, sequencer and datapath
//
// input stream (in_*): each transaction is either a matrix entry load (in_tuser kind 0)
// or one weighted bone term of a vertex (kind 1); in_tlast marks a vertex's final term.
// a load writes one Q16.16 entry of a bone's row-major 3x4 matrix.
// a term walks the twelve entries of its bone through the single read port of the bone
// store, one entry a cycle, through a shared 32x32 multiplier, an exact row sum, a Q16
// weight multiply and a saturating 64-bit accumulate per axis, then drains the pipeline;
// a term that closes a vertex then also loads the output register.
// in_tready stays low while a term is in flight, so the next transaction waits for it.
// output stream (out_*): one transaction per vertex, positions saturated to 32 bits,
// with the clip flag in out_tuser.
// the output register parts the two sides: a held result does not block new input
// until another vertex is ready to emit, which then waits for the register to drain.
// reset (synchronous, rst_n low) clears the sequencer, the accumulators and
// out_tvalid; the bone store is not cleared and must be loaded before use.
`default_nettype none

module linear_blend_skinning_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // bone[5:0] entry[9:6] entry_value[41:10] weight[58:42] offset_x[90:59]
  // offset_y[122:91] offset_z[154:123], zero pad above
  input  wire logic [lbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[0] first_term[1]
  input  wire logic [lbs_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic                               in_tlast,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // pos_x[31:0] pos_y[63:32] pos_z[95:64]
  output logic [lbs_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // clipped[0]
  output logic [0:0]                              out_tuser
);

  lbs_pkg::lbs_cmd_t    cmd;
  lbs_pkg::lbs_status_t status;
  logic                 clip;

  // field unpacking
  logic                              kind;
  logic [lbs_pkg::BONE_W-1:0]        bone;
  logic [lbs_pkg::ENTRY_W-1:0]       entry;
  logic signed [lbs_pkg::DATA_W-1:0] entry_value;
  logic [lbs_pkg::WEIGHT_W-1:0]      weight;
  logic signed [lbs_pkg::DATA_W-1:0] offset_x, offset_y, offset_z;
  logic                              first_term;

  assign kind        = in_tuser[0];
  assign first_term  = in_tuser[1];
  assign bone        = in_tdata[5:0];
  assign entry       = in_tdata[9:6];
  assign entry_value = $signed(in_tdata[41:10]);
  assign weight      = in_tdata[58:42];
  assign offset_x    = $signed(in_tdata[90:59]);
  assign offset_y    = $signed(in_tdata[122:91]);
  assign offset_z    = $signed(in_tdata[154:123]);

  // sequencer
  lbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (kind),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // store, arithmetic and output register
  lbs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (kind),
    .in_bone        (bone),
    .in_entry       (entry),
    .in_entry_value (entry_value),
    .in_weight      (weight),
    .in_offset_x    (offset_x),
    .in_offset_y    (offset_y),
    .in_offset_z    (offset_z),
    .in_first       (first_term),
    .out_tready     (out_tready),
    .out_data       (out_tdata),
    .out_clip       (clip)
  );

  assign out_tvalid   = status.out_valid;
  assign out_tuser[0] = clip;

endmodule

`default_nettype wire

// ===== hdl/lbs_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lbs_datapath.sv =====
// bone store, multiply pipeline, accumulators and output register
`default_nettype none

module lbs_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lbs_pkg::lbs_cmd_t                     cmd,
  output lbs_pkg::lbs_status_t                       status,
  input  wire logic                                  in_kind,
  input  wire logic [lbs_pkg::BONE_W-1:0]            in_bone,
  input  wire logic [lbs_pkg::ENTRY_W-1:0]           in_entry,
  input  wire logic signed [lbs_pkg::DATA_W-1:0]     in_entry_value,
  input  wire logic [lbs_pkg::WEIGHT_W-1:0]          in_weight,
  input  wire logic signed [lbs_pkg::DATA_W-1:0]     in_offset_x,
  input  wire logic signed [lbs_pkg::DATA_W-1:0]     in_offset_y,
  input  wire logic signed [lbs_pkg::DATA_W-1:0]     in_offset_z,
  input  wire logic                                  in_first,
  input  wire logic                                  out_tready,
  output logic [lbs_pkg::OUT_TDATA_W-1:0]            out_data,
  output logic                                       out_clip
);

  localparam int ADDR_CALC_W = lbs_pkg::BONE_W + 4;

  // captured term
  logic [lbs_pkg::BONE_W-1:0]        bone_r;
  logic                              bone_ok_r;
  logic [lbs_pkg::WEIGHT_W-1:0]      weight_r;
  logic signed [lbs_pkg::DATA_W-1:0] off_r [lbs_pkg::AXES];
  logic                              first_r;

  // store access
  logic                              wr_en;
  logic [lbs_pkg::STORE_AW-1:0]      wr_addr;
  logic [lbs_pkg::STORE_AW-1:0]      rd_addr;
  logic [lbs_pkg::DATA_W-1:0]        rd_data;

  // pipeline
  logic                              v1_r, v2_r, v3_r, v4_r;
  logic [lbs_pkg::ENTRY_W-1:0]       e1_r, e2_r, e3_r;
  logic [1:0]                        row4_r;
  logic signed [lbs_pkg::DATA_W-1:0] m1;
  logic signed [lbs_pkg::DATA_W-1:0] o_sel;
  logic signed [lbs_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic signed [lbs_pkg::RSUM_W-1:0] rsum_nxt, rsum_r;
  logic signed [lbs_pkg::T_W-1:0]    t_val;
  logic signed [lbs_pkg::WEIGHT_W:0] w_s;
  logic signed [lbs_pkg::WP_W-1:0]   wp_nxt, wp_r;
  logic signed [lbs_pkg::ACC_W-1:0]  s_val;
  logic signed [lbs_pkg::ACC_W-1:0]  acc_base;
  logic signed [lbs_pkg::ACC_W:0]    acc_sum;
  logic signed [lbs_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [lbs_pkg::ACC_W-1:0]  acc_r [lbs_pkg::AXES];

  // output
  logic                              out_valid_r;
  logic [lbs_pkg::OUT_TDATA_W-1:0]   out_data_r;
  logic                              out_clip_r;
  logic [lbs_pkg::OUT_TDATA_W-1:0]   sat_data;
  logic [lbs_pkg::AXES-1:0]          sat_clip;

  // ---------------- bone store ----------------
  assign wr_en = cmd.accept && (in_kind == lbs_pkg::KIND_LOAD)
                 && (in_entry <= lbs_pkg::LAST_ENTRY)
                 && (32'(in_bone) < 32'(lbs_pkg::MAX_BONES));
  assign wr_addr = lbs_pkg::STORE_AW'(ADDR_CALC_W'({in_bone, 3'b000})
                                      + ADDR_CALC_W'({in_bone, 2'b00})
                                      + ADDR_CALC_W'(in_entry));
  assign rd_addr = lbs_pkg::STORE_AW'(ADDR_CALC_W'({bone_r, 3'b000})
                                      + ADDR_CALC_W'({bone_r, 2'b00})
                                      + ADDR_CALC_W'(cmd.rd_entry));

  lbs_ram #(
    .WIDTH (lbs_pkg::DATA_W),
    .DEPTH (lbs_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (in_entry_value),
    .re      (cmd.rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // capture of a term, weight clamped to one
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bone_r    <= in_bone;
      bone_ok_r <= 32'(in_bone) < 32'(lbs_pkg::MAX_BONES);
      weight_r  <= (in_weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : in_weight;
      off_r[0]  <= in_offset_x;
      off_r[1]  <= in_offset_y;
      off_r[2]  <= in_offset_z;
      first_r   <= in_first;
    end
  end

  // ---------------- stage 1: entry times offset ----------------
  assign m1 = bone_ok_r ? $signed(rd_data) : '0;

  always_comb begin
    unique case (e1_r[1:0])
      2'd0:    o_sel = off_r[0];
      2'd1:    o_sel = off_r[1];
      2'd2:    o_sel = off_r[2];
      default: o_sel = '0;
    endcase
  end

  // the translation column enters the row sum pre-scaled
  assign prod_nxt = (e1_r[1:0] == lbs_pkg::TRANS_COL)
                    ? (lbs_pkg::PROD_W'(m1) <<< lbs_pkg::FRAC_BITS)
                    : m1 * o_sel;

  // ---------------- stage 2: exact row sum ----------------
  assign rsum_nxt = ((e2_r[1:0] == 2'd0) ? '0 : rsum_r) + lbs_pkg::RSUM_W'(prod_r);

  // ---------------- stage 3: weight scaling ----------------
  assign t_val  = lbs_pkg::T_W'(rsum_r >>> lbs_pkg::FRAC_BITS);
  assign w_s    = $signed({1'b0, weight_r});
  assign wp_nxt = lbs_pkg::WP_W'(t_val) * lbs_pkg::WP_W'(w_s);

  // ---------------- stage 4: saturating accumulate ----------------
  assign s_val    = lbs_pkg::ACC_W'(wp_r >>> lbs_pkg::WEIGHT_BITS);
  assign acc_base = first_r ? '0 : acc_r[row4_r];
  assign acc_sum  = {acc_base[lbs_pkg::ACC_W-1], acc_base} + {s_val[lbs_pkg::ACC_W-1], s_val};

  always_comb begin
    if (acc_sum[lbs_pkg::ACC_W] != acc_sum[lbs_pkg::ACC_W-1]) begin
      acc_nxt = acc_sum[lbs_pkg::ACC_W] ? {1'b1, {(lbs_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(lbs_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_sum[lbs_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int a = 0; a < lbs_pkg::AXES; a++) begin
        acc_r[a] <= '0;
      end
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && (e3_r[1:0] == lbs_pkg::TRANS_COL);
      if (v4_r) begin
        acc_r[row4_r] <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    e1_r <= cmd.rd_entry;
    e2_r <= e1_r;
    e3_r <= e2_r;
    row4_r <= e3_r[3:2];
    if (v1_r) begin
      prod_r <= prod_nxt;
    end
    if (v2_r) begin
      rsum_r <= rsum_nxt;
    end
    if (v3_r) begin
      wp_r <= wp_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    for (int a = 0; a < lbs_pkg::AXES; a++) begin
      if (acc_r[a][lbs_pkg::ACC_W-1:lbs_pkg::DATA_W-1] != {(lbs_pkg::ACC_W-lbs_pkg::DATA_W+1){1'b0}}
          && acc_r[a][lbs_pkg::ACC_W-1:lbs_pkg::DATA_W-1]
             != {(lbs_pkg::ACC_W-lbs_pkg::DATA_W+1){1'b1}}) begin
        sat_clip[a] = 1'b1;
        sat_data[a*lbs_pkg::DATA_W +: lbs_pkg::DATA_W] =
          acc_r[a][lbs_pkg::ACC_W-1] ? {1'b1, {(lbs_pkg::DATA_W-1){1'b0}}}
                                     : {1'b0, {(lbs_pkg::DATA_W-1){1'b1}}};
      end else begin
        sat_clip[a] = 1'b0;
        sat_data[a*lbs_pkg::DATA_W +: lbs_pkg::DATA_W] = acc_r[a][lbs_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= sat_data;
      out_clip_r <= |sat_clip;
    end
  end

  assign status.out_valid = out_valid_r;
  assign out_data         = out_data_r;
  assign out_clip         = out_clip_r;

endmodule

`default_nettype wire

// ===== hdl/lbs_ctrl.sv =====
// sequencer: accepts items, walks the twelve matrix reads, drains and emits
`default_nettype none

module lbs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_kind,
  input  wire logic                 in_last,
  input  wire logic                 out_tready,
  input  wire lbs_pkg::lbs_status_t status,
  output lbs_pkg::lbs_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [lbs_pkg::ENTRY_W-1:0] DRAIN_LAST =
    lbs_pkg::ENTRY_W'(lbs_pkg::DRAIN_CYCLES - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [lbs_pkg::ENTRY_W-1:0] cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;
  logic                        accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    cmd.accept   = accept;
    cmd.rd_en    = 1'b0;
    cmd.rd_entry = cnt_r;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == lbs_pkg::KIND_TERM)) begin
          state_nxt = ST_READ;
          cnt_nxt   = '0;
          last_nxt  = in_last;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == lbs_pkg::LAST_ENTRY) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == DRAIN_LAST) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!status.out_valid || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> cnt_r <= lbs_pkg::LAST_ENTRY)
    else $error("matrix read counter beyond last entry");

  a_term_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == lbs_pkg::KIND_TERM) |=> state_r == ST_READ && cnt_r == '0)
    else $error("term transaction did not start the matrix walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!status.out_valid || out_tready))
    else $error("output register loaded over an untaken result");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.rd_en)
    else $error("store read while accepting input");

endmodule

`default_nettype wire
